@@ hw/rtl/mi3_pkg.sv @@
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

    localparam int ELEM_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ELEM      = 9;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv00;
        logic signed [ELEM_W-1:0] inv01;
        logic signed [ELEM_W-1:0] inv02;
        logic signed [ELEM_W-1:0] inv10;
        logic signed [ELEM_W-1:0] inv11;
        logic signed [ELEM_W-1:0] inv12;
        logic signed [ELEM_W-1:0] inv20;
        logic signed [ELEM_W-1:0] inv21;
        logic signed [ELEM_W-1:0] inv22;
        logic                     singular;
        logic                     saturated;
    } inv_t;

endpackage

@@ hw/rtl/mi3_cofactor.sv @@
// Cofactor stages: 2x2 minor products, then signed differences.
module mi3_cofactor
    import mi3_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [ELEM_W-1:0]   elem [NUM_ELEM],
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [2*ELEM_W:0]   cof [NUM_ELEM],
    output logic signed [ELEM_W-1:0]   col0 [3]
);

    // cyclic neighbors give the cofactor sign for free
    function automatic int nxt3(input int i);
        return (i == 2) ? 0 : i + 1;
    endfunction

    function automatic int prv3(input int i);
        return (i == 0) ? 2 : i - 1;
    endfunction

    logic                       va_reg;
    logic                       vb_reg;
    logic                       rdy_a;
    logic                       rdy_b;
    logic signed [2*ELEM_W-1:0] prod_a_reg [NUM_ELEM];
    logic signed [2*ELEM_W-1:0] prod_b_reg [NUM_ELEM];
    logic signed [ELEM_W-1:0]   col0_a_reg [3];
    logic signed [2*ELEM_W:0]   cof_reg    [NUM_ELEM];
    logic signed [ELEM_W-1:0]   col0_b_reg [3];

    assign rdy_b    = !vb_reg || out_ready;
    assign rdy_a    = !va_reg || rdy_b;
    assign in_ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                va_reg <= in_valid;
            if (rdy_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                col0_a_reg[r] <= elem[r*3];
                for (int c = 0; c < 3; c++)
                begin
                    prod_a_reg[r*3+c] <= elem[nxt3(r)*3+nxt3(c)] * elem[prv3(r)*3+prv3(c)];
                    prod_b_reg[r*3+c] <= elem[nxt3(r)*3+prv3(c)] * elem[prv3(r)*3+nxt3(c)];
                end
            end
        end
        if (rdy_b && va_reg)
        begin
            for (int k = 0; k < NUM_ELEM; k++)
                cof_reg[k] <= prod_a_reg[k] - prod_b_reg[k];
            for (int r = 0; r < 3; r++)
                col0_b_reg[r] <= col0_a_reg[r];
        end
    end

    assign out_valid = vb_reg;
    assign cof       = cof_reg;
    assign col0      = col0_b_reg;

endmodule

@@ hw/rtl/mi3_det.sv @@
// Determinant stages: split products, row sums, total, magnitude and sign.
module mi3_det
    import mi3_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [2*ELEM_W:0]  cof [NUM_ELEM],
    input  logic signed [ELEM_W-1:0]  col0 [3],
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2*ELEM_W-1:0]       amag [NUM_ELEM],
    output logic [NUM_ELEM-1:0]       aneg,
    output logic [3*ELEM_W-1:0]       dmag,
    output logic                      dneg,
    output logic                      sing
);

    localparam int DW = 3 * ELEM_W + 2;
    localparam int NST = 4;

    logic                      v_reg [NST];
    logic                      rdy   [NST];

    // stage C
    logic signed [2*ELEM_W:0]  pl_reg  [3];
    logic signed [2*ELEM_W:0]  ph_reg  [3];
    logic signed [2*ELEM_W:0]  cof_c_reg [NUM_ELEM];
    // stage D
    logic signed [DW-1:0]      row_reg [3];
    logic [2*ELEM_W-1:0]       amag_d_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0]       aneg_d_reg;
    // stage E
    logic signed [DW-1:0]      det_reg;
    logic [2*ELEM_W-1:0]       amag_e_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0]       aneg_e_reg;
    // stage F
    logic [3*ELEM_W-1:0]       dmag_reg;
    logic                      dneg_reg;
    logic                      sing_reg;
    logic [2*ELEM_W-1:0]       amag_f_reg [NUM_ELEM];
    logic [NUM_ELEM-1:0]       aneg_f_reg;

    logic signed [DW-1:0]      row_next [3];
    logic signed [DW-1:0]      ext_h    [3];
    logic signed [DW-1:0]      ext_l    [3];
    logic signed [2*ELEM_W:0]  cof_neg  [NUM_ELEM];
    logic signed [DW-1:0]      det_neg;

    always_comb
    begin
        rdy[NST-1] = !v_reg[NST-1] || out_ready;
        for (int s = NST - 2; s >= 0; s--)
            rdy[s] = !v_reg[s] || rdy[s+1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
                v_reg[s] <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
                if (rdy[s])
                    v_reg[s] <= v_reg[s-1];
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            ext_h[r]    = ph_reg[r];
            ext_l[r]    = pl_reg[r];
            row_next[r] = (ext_h[r] <<< ELEM_W) + ext_l[r];
        end
        for (int k = 0; k < NUM_ELEM; k++)
            cof_neg[k] = -cof_c_reg[k];
        det_neg = -det_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            // cofactor split into an unsigned low half and a signed high half
            for (int r = 0; r < 3; r++)
            begin
                pl_reg[r] <= col0[r] * $signed({1'b0, cof[r*3][ELEM_W-1:0]});
                ph_reg[r] <= col0[r] * $signed(cof[r*3][2*ELEM_W:ELEM_W]);
            end
            for (int k = 0; k < NUM_ELEM; k++)
                cof_c_reg[k] <= cof[k];
        end
        if (rdy[1] && v_reg[0])
        begin
            for (int r = 0; r < 3; r++)
                row_reg[r] <= row_next[r];
            // transpose: lane r*3+c takes cofactor c*3+r
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    aneg_d_reg[r*3+c] <= cof_c_reg[c*3+r][2*ELEM_W];
                    amag_d_reg[r*3+c] <= cof_c_reg[c*3+r][2*ELEM_W] ?
                                         cof_neg[c*3+r][2*ELEM_W-1:0] :
                                         cof_c_reg[c*3+r][2*ELEM_W-1:0];
                end
            end
        end
        if (rdy[2] && v_reg[1])
        begin
            det_reg    <= row_reg[0] + row_reg[1] + row_reg[2];
            amag_e_reg <= amag_d_reg;
            aneg_e_reg <= aneg_d_reg;
        end
        if (rdy[3] && v_reg[2])
        begin
            dneg_reg   <= det_reg[DW-1];
            dmag_reg   <= det_reg[DW-1] ? det_neg[3*ELEM_W-1:0] : det_reg[3*ELEM_W-1:0];
            sing_reg   <= (det_reg == '0);
            amag_f_reg <= amag_e_reg;
            aneg_f_reg <= aneg_e_reg;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign amag      = amag_f_reg;
    assign aneg      = aneg_f_reg;
    assign dmag      = dmag_reg;
    assign dneg      = dneg_reg;
    assign sing      = sing_reg;

endmodule

@@ hw/rtl/mi3_divide.sv @@
// Nine-lane pipelined restoring divider, one quotient bit per stage.
module mi3_divide
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [2*ELEM_W-1:0]       amag [NUM_ELEM],
    input  logic [NUM_ELEM-1:0]       aneg,
    input  logic [3*ELEM_W-1:0]       dmag,
    input  logic                      dneg,
    input  logic                      sing,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ELEM_W:0]           quo [NUM_ELEM],
    output logic [NUM_ELEM-1:0]       aneg_out,
    output logic                      dneg_out,
    output logic                      sing_out
);

    localparam int NS  = ELEM_W + 1;
    localparam int NW  = 2 * ELEM_W + 2 * FRAC_BITS;
    localparam int CW  = (NW > 4 * ELEM_W) ? NW : 4 * ELEM_W;
    localparam int QW  = ELEM_W + 1;
    localparam int DMW = 3 * ELEM_W;

    logic                 v_reg    [NS];
    logic [NW-1:0]        rem_reg  [NS][NUM_ELEM];
    logic [QW-1:0]        q_reg    [NS][NUM_ELEM];
    logic [DMW-1:0]       dmag_reg [NS];
    logic                 dneg_reg [NS];
    logic                 sing_reg [NS];
    logic [NUM_ELEM-1:0]  aneg_reg [NS];
    wire  [NS-1:0]        st_rdy;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        // top stage tests bit ELEM_W: set means the quotient overflows
        localparam int BIT = ELEM_W - s;

        logic                v_in;
        logic [NW-1:0]       rem_in   [NUM_ELEM];
        logic [QW-1:0]       q_in     [NUM_ELEM];
        logic [DMW-1:0]      dmag_in;
        logic                dneg_in;
        logic                sing_in;
        logic [NUM_ELEM-1:0] aneg_in;
        logic [CW-1:0]       dsh;
        logic [CW-1:0]       rext     [NUM_ELEM];
        logic [CW-1:0]       diff     [NUM_ELEM];
        logic [NW-1:0]       rem_next [NUM_ELEM];
        logic [QW-1:0]       q_next   [NUM_ELEM];

        if (s == 0)
        begin : g_first
            always_comb
            begin
                v_in    = in_valid;
                dmag_in = dmag;
                dneg_in = dneg;
                sing_in = sing;
                aneg_in = aneg;
                for (int k = 0; k < NUM_ELEM; k++)
                begin
                    rem_in[k] = NW'(amag[k]) << (2 * FRAC_BITS);
                    q_in[k]   = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                v_in    = v_reg[s-1];
                dmag_in = dmag_reg[s-1];
                dneg_in = dneg_reg[s-1];
                sing_in = sing_reg[s-1];
                aneg_in = aneg_reg[s-1];
                for (int k = 0; k < NUM_ELEM; k++)
                begin
                    rem_in[k] = rem_reg[s-1][k];
                    q_in[k]   = q_reg[s-1][k];
                end
            end
        end

        if (s == NS - 1)
        begin : g_last_rdy
            assign st_rdy[s] = !v_reg[s] || out_ready;
        end
        else
        begin : g_mid_rdy
            assign st_rdy[s] = !v_reg[s] || st_rdy[s+1];
        end

        always_comb
        begin
            dsh = CW'(dmag_in) << BIT;
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                rext[k]      = CW'(rem_in[k]);
                diff[k]      = rext[k] - dsh;
                q_next[k]    = q_in[k];
                q_next[k][BIT] = (rext[k] >= dsh);
                rem_next[k]  = (rext[k] >= dsh) ? diff[k][NW-1:0] : rem_in[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (st_rdy[s])
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (st_rdy[s] && v_in)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                dmag_reg[s] <= dmag_in;
                dneg_reg[s] <= dneg_in;
                sing_reg[s] <= sing_in;
                aneg_reg[s] <= aneg_in;
            end
        end
    end

    assign in_ready  = st_rdy[0];
    assign out_valid = v_reg[NS-1];
    assign quo       = q_reg[NS-1];
    assign aneg_out  = aneg_reg[NS-1];
    assign dneg_out  = dneg_reg[NS-1];
    assign sing_out  = sing_reg[NS-1];

endmodule

@@ hw/rtl/mi3_result.sv @@
// Output register: sign, saturation and singular handling.
module mi3_result
    import mi3_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ELEM_W:0]      quo [NUM_ELEM],
    input  logic [NUM_ELEM-1:0]  aneg,
    input  logic                 dneg,
    input  logic                 sing,
    output logic                 out_valid,
    input  logic                 out_ready,
    output inv_t                 result
);

    localparam logic [ELEM_W-1:0] MAX_POS = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] MIN_NEG = {1'b1, {(ELEM_W-1){1'b0}}};

    logic                v_reg;
    inv_t                res_reg;
    inv_t                res_next;
    logic [ELEM_W-1:0]   val  [NUM_ELEM];
    logic [NUM_ELEM-1:0] clip;
    logic [NUM_ELEM-1:0] ovf;
    logic [NUM_ELEM-1:0] qneg;

    assign in_ready = !v_reg || out_ready;

    always_comb
    begin
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            ovf[k]  = quo[k][ELEM_W];
            qneg[k] = (aneg[k] != dneg) && (ovf[k] || (quo[k][ELEM_W-1:0] != '0));
            if (sing)
            begin
                val[k]  = '0;
                clip[k] = 1'b0;
            end
            else if (!qneg[k])
            begin
                clip[k] = ovf[k] || quo[k][ELEM_W-1];
                val[k]  = clip[k] ? MAX_POS : quo[k][ELEM_W-1:0];
            end
            else
            begin
                // magnitude 2^(W-1) still fits as the most negative value
                clip[k] = ovf[k] || (quo[k][ELEM_W-1] && (quo[k][ELEM_W-2:0] != '0));
                val[k]  = clip[k] ? MIN_NEG : -quo[k][ELEM_W-1:0];
            end
        end
        res_next.inv00     = val[0];
        res_next.inv01     = val[1];
        res_next.inv02     = val[2];
        res_next.inv10     = val[3];
        res_next.inv11     = val[4];
        res_next.inv12     = val[5];
        res_next.inv20     = val[6];
        res_next.inv21     = val[7];
        res_next.inv22     = val[8];
        res_next.singular  = sing;
        res_next.saturated = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            res_reg <= res_next;
    end

    assign out_valid = v_reg;
    assign result    = res_reg;

endmodule

@@ hw/rtl/matrix3_inverse.sv @@
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
// Request channel: matrix_valid / matrix_ready carry one 3x3 matrix of
// signed Q16.16 elements (mat_t). Result channel: result_valid /
// result_ready carry the nine inverse elements plus singular and
// saturated flags (inv_t). Both sides use a plain valid/ready handshake.
//
// From request to result the pipe runs through 2 cofactor stages,
// 4 determinant stages, 33 divider stages (one quotient bit each, the
// first one flagging overflow) and the output register.
// Throughput is one matrix per cycle if not stalled; the bit-per-stage
// divider lanes set the depth, and each stage holds a request of its own.
//
// Each stage has a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so a stalled receiver backs the pipe up without
// losing or repeating a request, and bubbles are squeezed out.
// Reset clears all valid bits; datapath registers are not reset.
// A zero determinant yields all-zero elements with singular set.
module matrix3_inverse
    import mi3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  matrix_valid,
    output logic  matrix_ready,
    input  mat_t  matrix,
    output logic  result_valid,
    input  logic  result_ready,
    output inv_t  result
);

    logic signed [ELEM_W-1:0]  elem [NUM_ELEM];

    // cofactor -> determinant
    logic                      cof_valid;
    logic                      cof_ready;
    logic signed [2*ELEM_W:0]  cof  [NUM_ELEM];
    logic signed [ELEM_W-1:0]  col0 [3];

    // determinant -> divider
    logic                      det_valid;
    logic                      det_ready;
    logic [2*ELEM_W-1:0]       amag [NUM_ELEM];
    logic [NUM_ELEM-1:0]       aneg;
    logic [3*ELEM_W-1:0]       dmag;
    logic                      dneg;
    logic                      sing;

    // divider -> output register
    logic                      div_valid;
    logic                      div_ready;
    logic [ELEM_W:0]           quo [NUM_ELEM];
    logic [NUM_ELEM-1:0]       div_aneg;
    logic                      div_dneg;
    logic                      div_sing;

    // row-major flattening
    assign elem[0] = matrix.m00;
    assign elem[1] = matrix.m01;
    assign elem[2] = matrix.m02;
    assign elem[3] = matrix.m10;
    assign elem[4] = matrix.m11;
    assign elem[5] = matrix.m12;
    assign elem[6] = matrix.m20;
    assign elem[7] = matrix.m21;
    assign elem[8] = matrix.m22;

    mi3_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (matrix_valid),
        .in_ready  (matrix_ready),
        .elem      (elem),
        .out_valid (cof_valid),
        .out_ready (cof_ready),
        .cof       (cof),
        .col0      (col0)
    );

    // determinant path also transposes the cofactors into the adjugate
    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cof_valid),
        .in_ready  (cof_ready),
        .cof       (cof),
        .col0      (col0),
        .out_valid (det_valid),
        .out_ready (det_ready),
        .amag      (amag),
        .aneg      (aneg),
        .dmag      (dmag),
        .dneg      (dneg),
        .sing      (sing)
    );

    // numerator is |adj| scaled by 2^(2*FRAC_BITS) inside the divider
    mi3_divide #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (det_valid),
        .in_ready  (det_ready),
        .amag      (amag),
        .aneg      (aneg),
        .dmag      (dmag),
        .dneg      (dneg),
        .sing      (sing),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quo       (quo),
        .aneg_out  (div_aneg),
        .dneg_out  (div_dneg),
        .sing_out  (div_sing)
    );

    mi3_result u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .quo       (quo),
        .aneg      (div_aneg),
        .dneg      (div_dneg),
        .sing      (div_sing),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .result    (result)
    );

endmodule

@@ dv/mi3_inverse_checker.sv @@
// Checker for the 3x3 matrix inverse: predicts each inverse and compares results in order.
`timescale 1ns / 100ps
module mi3_inverse_checker
    import mi3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic matrix_valid,
    input  logic matrix_ready,
    input  mat_t matrix,
    input  logic result_valid,
    input  logic result_ready,
    input  inv_t result,
    output int   errors,
    output int   pending
);

    inv_t expected_inverses[$];

    // Exact adjugate / determinant with one truncating division per element.
    function automatic inv_t predict_inverse(mat_t mx);
        logic signed [31:0]  el[3][3];
        logic signed [127:0] w[3][3];
        logic signed [127:0] cof[3][3];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        amag;
        logic [127:0]        q;
        logic                aneg;
        logic                dneg;
        logic [31:0]         val[9];
        inv_t                res;
        res = '0;
        el[0][0] = mx.m00; el[0][1] = mx.m01; el[0][2] = mx.m02;
        el[1][0] = mx.m10; el[1][1] = mx.m11; el[1][2] = mx.m12;
        el[2][0] = mx.m20; el[2][1] = mx.m21; el[2][2] = mx.m22;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                w[r][c] = el[r][c];
        // cyclic row/column picks carry the cofactor sign
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                cof[r][c] = w[(r+1)%3][(c+1)%3] * w[(r+2)%3][(c+2)%3]
                          - w[(r+1)%3][(c+2)%3] * w[(r+2)%3][(c+1)%3];
        det = w[0][0] * cof[0][0] + w[1][0] * cof[1][0] + w[2][0] * cof[2][0];
        if (det == 0)
        begin
            res.singular = 1'b1;
            return res;
        end
        dneg = det[127];
        dmag = dneg ? -det : det;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                aneg = cof[c][r][127];
                amag = aneg ? -cof[c][r] : cof[c][r];
                q = (amag << (2 * FRAC_BITS_DEF)) / dmag;
                if ((aneg != dneg) && (q != 0))
                begin
                    if (q > 128'h8000_0000)
                    begin
                        q = 128'h8000_0000;
                        res.saturated = 1'b1;
                    end
                    q = -q;
                end
                else if (q > 128'h7FFF_FFFF)
                begin
                    q = 128'h7FFF_FFFF;
                    res.saturated = 1'b1;
                end
                val[r*3+c] = q[31:0];
            end
        res.inv00 = val[0]; res.inv01 = val[1]; res.inv02 = val[2];
        res.inv10 = val[3]; res.inv11 = val[4]; res.inv12 = val[5];
        res.inv20 = val[6]; res.inv21 = val[7]; res.inv22 = val[8];
        return res;
    endfunction

    initial errors = 0;
    initial pending = 0;

    always @(posedge clk)
    begin
        inv_t want;
        if (rst_n)
        begin
            if (matrix_valid && matrix_ready)
                expected_inverses.push_back(predict_inverse(matrix));
            if (result_valid && result_ready)
            begin
                if (expected_inverses.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, result);
                end
                else
                begin
                    want = expected_inverses.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (want[289-32*k -: 32] !== result[289-32*k -: 32])
                        begin
                            errors++;
                            $display("%0t: element %0d expected %h actual %h", $time, k,
                                     want[289-32*k -: 32], result[289-32*k -: 32]);
                        end
                    if (want.singular !== result.singular)
                    begin
                        errors++;
                        $display("%0t: singular expected %b actual %b", $time,
                                 want.singular, result.singular);
                    end
                    if (want.saturated !== result.saturated)
                    begin
                        errors++;
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, result.saturated);
                    end
                end
            end
        end
        pending = expected_inverses.size();
    end

endmodule

@@ dv/tb_matrix3_inverse.sv @@
// Testbench top for the 3x3 matrix inverse: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_matrix3_inverse;
    import mi3_pkg::*;

    localparam int ONE       = 32'h0001_0000;  // 1.0 in Q16.16
    localparam int HOLD_LEN  = 300;            // long receiver hold-off
    localparam int DOG_LIMIT = 20000;          // cycles with no handshake at all
    localparam int TAIL      = 80;             // settling wait after the final drain

    logic clk;
    logic rst_n;
    logic matrix_valid;
    logic matrix_ready;
    mat_t matrix;
    logic result_valid;
    logic result_ready;
    inv_t result;

    int errors;
    int pending;
    int src_idle_pct;    // chance the sender sits out a cycle
    int sink_stall_pct;  // chance the receiver drops ready
    int hold_left;       // remaining cycles of a forced receiver hold-off

    matrix3_inverse uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .matrix_valid (matrix_valid),
        .matrix_ready (matrix_ready),
        .matrix       (matrix),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    mi3_inverse_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .matrix_valid (matrix_valid),
        .matrix_ready (matrix_ready),
        .matrix       (matrix),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
                result_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: a stretch with no handshake on either channel that reaches DOG_LIMIT is a hang.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((matrix_valid && matrix_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= DOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it; returns once accepted.
    task automatic send_matrix(input mat_t v);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            matrix_valid <= 1'b0;
            @(negedge clk);
        end
        matrix_valid <= 1'b1;
        matrix       <= v;
        do
            @(posedge clk);
        while (!matrix_ready);
    endtask

    task automatic drain_results;
        @(negedge clk);
        matrix_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic mat_t uniform_mat(input logic signed [31:0] v);
        mat_t x;
        x = {9{v}};
        return x;
    endfunction

    function automatic mat_t diag_mat(input logic signed [31:0] a, input logic signed [31:0] b,
                                      input logic signed [31:0] c);
        mat_t x;
        x = '0;
        x.m00 = a;
        x.m11 = b;
        x.m22 = c;
        return x;
    endfunction

    // Random matrix: raw bits, small fixed-point values, small integers, or rank-deficient.
    function automatic mat_t random_mat;
        mat_t x;
        int   kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 9; k++)
        begin
            if (kind < 3)
                x[287-32*k -: 32] = $urandom;
            else if (kind < 6)
                x[287-32*k -: 32] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            else
                x[287-32*k -: 32] = ($signed($urandom_range(0, 4)) - 2) * ONE;
        end
        if (kind < 6 && $urandom_range(1))
        begin
            // boost the diagonal so the inverse stays well inside range
            x.m00 = x.m00 + 8 * ONE;
            x.m11 = x.m11 - 8 * ONE;
            x.m22 = x.m22 + 8 * ONE;
        end
        if (kind == 9)
        begin
            // duplicate a row: determinant is exactly zero
            x.m20 = x.m00;
            x.m21 = x.m01;
            x.m22 = x.m02;
        end
        return x;
    endfunction

    initial
    begin
        mat_t t;
        rst_n          = 1'b0;
        matrix_valid   = 1'b0;
        matrix         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity, zero, extremes, tiny pivots that saturate, negative det.
        send_matrix(diag_mat(ONE, ONE, ONE));
        send_matrix('0);
        send_matrix(uniform_mat(32'sh7FFF_FFFF));
        send_matrix(uniform_mat(32'sh8000_0000));
        send_matrix(diag_mat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send_matrix(diag_mat(1, 1, 1));
        send_matrix(diag_mat(-1, 1, 1));
        send_matrix(diag_mat(-ONE, 2 * ONE, ONE / 2));
        send_matrix(diag_mat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_matrix(diag_mat(ONE, ONE, 0));
        t = diag_mat(ONE, ONE, ONE);
        t.m01 = 32'sh7FFF_FFFF;
        t.m12 = 32'sh8000_0000;
        send_matrix(t);
        t = {32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0001,
             32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF,
             32'sh0000_0001, 32'shFFFF_FFFF, 32'sh8000_0000};
        send_matrix(t);
        t = {32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
             32'sh0000_0000, 32'sh0001_0000, 32'sh0004_0000,
             32'sh0005_0000, 32'sh0006_0000, 32'sh0000_0000};
        send_matrix(t);
        drain_results;

        // No idling, with a long receiver hold-off so the pipe backs up.
        hold_left = HOLD_LEN;
        repeat (200) send_matrix(random_mat());

        // Sender gaps, then a pause until every result is back.
        src_idle_pct = 72;
        repeat (200) send_matrix(random_mat());
        drain_results;

        src_idle_pct   = 0;
        sink_stall_pct = 72;
        repeat (200) send_matrix(random_mat());

        src_idle_pct   = 9;
        sink_stall_pct = 9;
        repeat (200) send_matrix(random_mat());

        drain_results;
        repeat (TAIL) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
